### hw/rtl/cbez_pkg.sv
// Shared types and constants for the cubic Bezier point evaluator.
// No dependencies; imported by the weight, axis and top-level modules.
`default_nettype none

package cbez_pkg;

  // Parameter t is unsigned Q1.16, 1.0 = 2^16
  localparam int unsigned T_W    = 17;
  localparam logic [T_W-1:0] T_ONE = 17'h10000;

  // Bernstein weights are unsigned Q.30, at most 2^30
  localparam int unsigned WGT_W  = 31;

  // Coordinates are signed Q16.16
  localparam int unsigned COORD_W = 32;

  // Configuration register file
  localparam int unsigned NUM_REGS  = 8;
  localparam int unsigned REG_IDX_W = 3;
  localparam int unsigned ADDR_W    = 5;

  // Register indexes of the configuration port
  typedef enum logic [REG_IDX_W-1:0] {
    REG_CTRL0_X = 3'd0,
    REG_CTRL0_Y = 3'd1,
    REG_CTRL1_X = 3'd2,
    REG_CTRL1_Y = 3'd3,
    REG_CTRL2_X = 3'd4,
    REG_CTRL2_Y = 3'd5,
    REG_CTRL3_X = 3'd6,
    REG_CTRL3_Y = 3'd7
  } cfg_reg_t;

  // The four rounded weights of one parameter sample
  typedef struct packed {
    logic [WGT_W-1:0] w0;  // (1-t)^3
    logic [WGT_W-1:0] w1;  // 3t(1-t)^2
    logic [WGT_W-1:0] w2;  // 3t^2(1-t)
    logic [WGT_W-1:0] w3;  // t^3
  } weights_t;

endpackage

`default_nettype wire

### hw/rtl/cbez_weights.sv
// Four-stage pipeline that turns a parameter t into the Bernstein weights.
// Depends on cbez_pkg for widths, T_ONE and weights_t.
`default_nettype none

module cbez_weights import cbez_pkg::*; (
  input  wire logic           clk,
  input  wire logic [T_W-1:0] curve_param,
  output weights_t            weights
);

  localparam logic [49:0] W_RND = 50'h0_0000_0002_0000;  // 2^17

  // Stage 0: clamp t to 1.0 and form s = 1 - t
  logic [T_W-1:0] t0_r, s0_r;
  logic [T_W-1:0] t_clamp;

  always_comb begin
    t_clamp = (curve_param > T_ONE) ? T_ONE : curve_param;
  end

  always_ff @(posedge clk) begin
    t0_r <= t_clamp;
    s0_r <= T_ONE - t_clamp;
  end

  // Stage 1: squares and cross term (17x17)
  logic [T_W-1:0] t1_r, s1_r;
  logic [33:0]    tt1_r, ss1_r, ts1_r;

  always_ff @(posedge clk) begin
    t1_r  <= t0_r;
    s1_r  <= s0_r;
    tt1_r <= 34'(t0_r * t0_r);
    ss1_r <= 34'(s0_r * s0_r);
    ts1_r <= 34'(t0_r * s0_r);
  end

  // Stage 2: cubes and mixed cubic terms (34x17), all below 2^49
  logic [50:0] sss_p, ttt_p, tss_p, tts_p;
  logic [48:0] sss2_r, ttt2_r, tss2_r, tts2_r;

  always_comb begin
    sss_p = 51'(ss1_r * s1_r);
    ttt_p = 51'(tt1_r * t1_r);
    tss_p = 51'(ts1_r * s1_r);
    tts_p = 51'(ts1_r * t1_r);
  end

  always_ff @(posedge clk) begin
    sss2_r <= sss_p[48:0];
    ttt2_r <= ttt_p[48:0];
    tss2_r <= tss_p[48:0];
    tts2_r <= tts_p[48:0];
  end

  // Stage 3: times three for the middle terms, round Q.48 to Q.30
  logic [49:0] r0, r1, r2, r3;
  weights_t    weights_r;

  always_comb begin
    r0 = {1'b0, sss2_r} + W_RND;
    r1 = {tss2_r, 1'b0} + {1'b0, tss2_r} + W_RND;
    r2 = {tts2_r, 1'b0} + {1'b0, tts2_r} + W_RND;
    r3 = {1'b0, ttt2_r} + W_RND;
  end

  always_ff @(posedge clk) begin
    weights_r.w0 <= r0[48:18];
    weights_r.w1 <= r1[48:18];
    weights_r.w2 <= r2[48:18];
    weights_r.w3 <= r3[48:18];
  end

  assign weights = weights_r;

endmodule

`default_nettype wire

### hw/rtl/cbez_axis.sv
// Three-stage weighted sum of four control coordinates for one axis,
// rounded to Q16.16 and saturated. Depends on cbez_pkg.
`default_nettype none

module cbez_axis import cbez_pkg::*; (
  input  wire logic                       clk,
  input  wire weights_t                   weights,
  input  wire logic signed [COORD_W-1:0]  c0,
  input  wire logic signed [COORD_W-1:0]  c1,
  input  wire logic signed [COORD_W-1:0]  c2,
  input  wire logic signed [COORD_W-1:0]  c3,
  output logic signed [COORD_W-1:0]       coord
);

  localparam logic signed [65:0] ACC_RND = 66'sh0_0000_0000_2000_0000;  // 2^29
  localparam logic signed [35:0] Q_MAX   = 36'sh0_7FFF_FFFF;
  localparam logic signed [35:0] Q_MIN   = -36'sh0_8000_0000;

  // Stage A: four 32x32 signed products
  logic signed [63:0] p0_r, p1_r, p2_r, p3_r;

  always_ff @(posedge clk) begin
    p0_r <= $signed({1'b0, weights.w0}) * c0;
    p1_r <= $signed({1'b0, weights.w1}) * c1;
    p2_r <= $signed({1'b0, weights.w2}) * c2;
    p3_r <= $signed({1'b0, weights.w3}) * c3;
  end

  // Stage B: exact sum
  logic signed [65:0] acc_nxt, acc_r;

  always_comb begin
    acc_nxt = 66'(p0_r) + 66'(p1_r) + 66'(p2_r) + 66'(p3_r);
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  // Stage C: round half up to Q16.16, then saturate
  logic signed [65:0]        acc_rnd;
  logic signed [35:0]        q;
  logic signed [COORD_W-1:0] coord_nxt, coord_r;

  always_comb begin
    acc_rnd = acc_r + ACC_RND;
    q       = acc_rnd[65:30];
    if (q > Q_MAX) begin
      coord_nxt = Q_MAX[COORD_W-1:0];
    end else if (q < Q_MIN) begin
      coord_nxt = Q_MIN[COORD_W-1:0];
    end else begin
      coord_nxt = q[COORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    coord_r <= coord_nxt;
  end

  assign coord = coord_r;

endmodule

`default_nettype wire

### hw/rtl/cubic_bezier_point_eval.sv
// Cubic Bezier point evaluator: one (x, y) point per request of t.
// out_strobe is high with each result, which passes through
// 4 stages of weight generation, then multiply, sum, round/saturate.
// Throughput: one request per cycle; busy is always low, no stalls.
// Reset (rst_n low, synchronous) clears the pipeline valid bits and all
// eight control registers to zero. Depends on cbez_pkg, cbez_weights, cbez_axis.
`default_nettype none

module cubic_bezier_point_eval import cbez_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  // request channel
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [T_W-1:0]      in_curve_param,
  // result channel
  output logic                     out_strobe,
  output logic [COORD_W-1:0]       out_point_x,
  output logic [COORD_W-1:0]       out_point_y,
  // configuration port
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [ADDR_W-1:0]   paddr,
  input  wire logic [COORD_W-1:0]  pwdata,
  output logic [COORD_W-1:0]       prdata,
  output logic                     pready
);

  localparam int unsigned LAT = 7;

  // Control point registers
  logic [COORD_W-1:0]   ctrl_r [NUM_REGS];
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 reg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign reg_wr  = psel && penable && pwrite && pready;
  assign prdata  = ctrl_r[reg_idx];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        ctrl_r[i] <= '0;
      end
    end else if (reg_wr) begin
      ctrl_r[reg_idx] <= pwdata;
    end
  end

  // Request accept and valid pipeline
  logic           accept;
  logic [LAT-1:0] vld_r;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LAT-2:0], accept};
    end
  end

  // Weight generation
  weights_t wgt;

  cbez_weights u_weights (
    .clk         (clk),
    .curve_param (in_curve_param),
    .weights     (wgt)
  );

  // Per-axis weighted sums
  logic signed [COORD_W-1:0] pt_x, pt_y;

  cbez_axis u_axis_x (
    .clk     (clk),
    .weights (wgt),
    .c0      ($signed(ctrl_r[REG_CTRL0_X])),
    .c1      ($signed(ctrl_r[REG_CTRL1_X])),
    .c2      ($signed(ctrl_r[REG_CTRL2_X])),
    .c3      ($signed(ctrl_r[REG_CTRL3_X])),
    .coord   (pt_x)
  );

  cbez_axis u_axis_y (
    .clk     (clk),
    .weights (wgt),
    .c0      ($signed(ctrl_r[REG_CTRL0_Y])),
    .c1      ($signed(ctrl_r[REG_CTRL1_Y])),
    .c2      ($signed(ctrl_r[REG_CTRL2_Y])),
    .c3      ($signed(ctrl_r[REG_CTRL3_Y])),
    .coord   (pt_y)
  );

  assign out_strobe  = vld_r[LAT-1];
  assign out_point_x = pt_x;
  assign out_point_y = pt_y;

  // Checks
  logic [WGT_W+1:0] wgt_sum;

  assign wgt_sum = (WGT_W+2)'(wgt.w0) + (WGT_W+2)'(wgt.w1)
                 + (WGT_W+2)'(wgt.w2) + (WGT_W+2)'(wgt.w3);

  // Rounded weights keep partition of unity within rounding error
  a_wgt_unity: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[3] |-> (wgt_sum >= 33'h0_3FFF_FFFE) && (wgt_sum <= 33'h0_4000_0002))
    else $error("Bezier weights do not sum to one");

  // Every result traces back to an earlier request
  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start, LAT))
    else $error("result strobe without matching request");

endmodule

`default_nettype wire
